FILE: design/frlm_pkg.sv
`default_nettype none
package frlm_pkg;

    // log geometry
    localparam int unsigned SLOTS  = 341;
    localparam int unsigned SLOT_W = 9;
    localparam int unsigned VAL_W  = 10;

    // record words
    localparam logic [31:0] LOG_MAGIC  = 32'h534F_4332;
    localparam logic [31:0] SUM_SALT   = 32'hA5A5_5A5A;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [15:0] ALL_ONES16 = 16'hFFFF;
    localparam logic [15:0] VAL_LIMIT  = 16'd1000;

    // stream widths
    localparam int unsigned S_TDATA_W = 152;
    localparam int unsigned M_TDATA_W = 112;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RECORD  = 2'd1,
        OP_SAVE    = 2'd2,
        OP_OUTCOME = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FLASH_ERR = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CLS_ERASED  = 2'd0,
        CLS_VALID   = 2'd1,
        CLS_INVALID = 2'd2
    } rec_class_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] rec_magic;
        logic [31:0] rec_sequence;
        logic [15:0] soc_min;
        logic [15:0] soc_max;
        logic [15:0] soc_avg;
        logic [31:0] rec_checksum;
        logic        read_ok;
        logic        erase_ok;
        logic        write_ok;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        rec_class_t        record_class;
        logic              ready_res;
        logic [SLOT_W-1:0] write_slot;
        logic              erase_first;
        logic [31:0]       write_sequence;
        logic [31:0]       write_checksum;
        logic              found;
        logic [VAL_W-1:0]  latest_min;
        logic [VAL_W-1:0]  latest_max;
        logic [VAL_W-1:0]  latest_avg;
    } result_t;

    // record check flags
    typedef struct packed {
        logic erased;
        logic valid;
        logic in_range;
    } rec_chk_t;

    // xor checksum over one record
    function automatic logic [31:0] calc_sum(
        input logic [31:0] magic,
        input logic [31:0] seq,
        input logic [15:0] a,
        input logic [15:0] b,
        input logic [15:0] c
    );
        calc_sum = magic ^ seq ^ {16'h0000, a} ^ {b, 16'h0000} ^ {16'h0000, c} ^ SUM_SALT;
    endfunction

endpackage
`default_nettype wire

FILE: design/frlm_rec_check.sv
`default_nettype none
module frlm_rec_check (
    input  wire frlm_pkg::in_item_t item,
    output frlm_pkg::rec_chk_t      chk
);
    import frlm_pkg::*;

    logic [31:0] sum_calc;

    // checksum of the incoming record
    assign sum_calc = calc_sum(item.rec_magic, item.rec_sequence,
                               item.soc_min, item.soc_max, item.soc_avg);

    // blank slot, charge limits and full validity
    always_comb begin
        chk.erased   = (item.rec_magic == ALL_ONES32) && (item.rec_sequence == ALL_ONES32) &&
                       (item.rec_checksum == ALL_ONES32) && (item.soc_min == ALL_ONES16) &&
                       (item.soc_max == ALL_ONES16) && (item.soc_avg == ALL_ONES16);
        chk.in_range = (item.soc_min <= VAL_LIMIT) && (item.soc_max <= VAL_LIMIT) &&
                       (item.soc_avg <= VAL_LIMIT);
        chk.valid    = (item.rec_magic == LOG_MAGIC) && chk.in_range &&
                       (item.rec_checksum == sum_calc);
    end

endmodule
`default_nettype wire

FILE: design/frlm_ctrl.sv
`default_nettype none
module frlm_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     fire,
    input  wire frlm_pkg::in_item_t item,
    input  wire frlm_pkg::rec_chk_t chk,
    output frlm_pkg::result_t       res
);
    import frlm_pkg::*;

    logic              ready_reg,        ready_next;
    logic              scan_active_reg,  scan_active_next;
    logic [SLOT_W-1:0] scan_index_reg,   scan_index_next;
    logic [SLOT_W-1:0] next_slot_reg,    next_slot_next;
    logic [31:0]       next_seq_reg,     next_seq_next;
    logic              have_latest_reg,  have_latest_next;
    logic [31:0]       latest_seq_reg,   latest_seq_next;
    logic [VAL_W-1:0]  latest_min_reg,   latest_min_next;
    logic [VAL_W-1:0]  latest_max_reg,   latest_max_next;
    logic [VAL_W-1:0]  latest_avg_reg,   latest_avg_next;
    logic              pend_save_reg,    pend_save_next;
    logic              pend_erase_reg,   pend_erase_next;
    logic [VAL_W-1:0]  pend_min_reg,     pend_min_next;
    logic [VAL_W-1:0]  pend_max_reg,     pend_max_next;
    logic [VAL_W-1:0]  pend_avg_reg,     pend_avg_next;

    logic [SLOT_W-1:0] scan_index_inc;
    logic [SLOT_W-1:0] plan_slot;
    logic              wrap;

    assign scan_index_inc = scan_index_reg + 1'b1;
    assign wrap           = (next_slot_reg >= SLOT_W'(SLOTS));
    assign plan_slot      = pend_erase_reg ? '0 : next_slot_reg;

    // per-request state update and result
    always_comb begin
        ready_next       = ready_reg;
        scan_active_next = scan_active_reg;
        scan_index_next  = scan_index_reg;
        next_slot_next   = next_slot_reg;
        next_seq_next    = next_seq_reg;
        have_latest_next = have_latest_reg;
        latest_seq_next  = latest_seq_reg;
        latest_min_next  = latest_min_reg;
        latest_max_next  = latest_max_reg;
        latest_avg_next  = latest_avg_reg;
        pend_save_next   = pend_save_reg;
        pend_erase_next  = pend_erase_reg;
        pend_min_next    = pend_min_reg;
        pend_max_next    = pend_max_reg;
        pend_avg_next    = pend_avg_reg;

        res                = '0;
        res.status         = ST_OK;
        res.record_class   = CLS_ERASED;

        case (item.op)
            OP_START: begin
                ready_next       = 1'b0;
                scan_active_next = 1'b1;
                scan_index_next  = '0;
                next_slot_next   = '0;
                next_seq_next    = 32'd1;
                have_latest_next = 1'b0;
                latest_seq_next  = '0;
                latest_min_next  = '0;
                latest_max_next  = '0;
                latest_avg_next  = '0;
                pend_save_next   = 1'b0;
                pend_erase_next  = 1'b0;
                pend_min_next    = '0;
                pend_max_next    = '0;
                pend_avg_next    = '0;
            end
            OP_RECORD: begin
                if (!scan_active_reg) begin
                    res.status = ST_IGNORED;
                end else if (!item.read_ok) begin
                    scan_active_next = 1'b0;
                    res.status       = ST_FLASH_ERR;
                end else if (chk.erased) begin
                    // first blank slot ends the scan
                    next_slot_next   = scan_index_reg;
                    scan_active_next = 1'b0;
                    ready_next       = 1'b1;
                end else begin
                    if (chk.valid) begin
                        res.record_class = CLS_VALID;
                        if (item.rec_sequence >= next_seq_reg) begin
                            next_seq_next = item.rec_sequence + 32'd1;
                        end
                        if (!have_latest_reg || (item.rec_sequence > latest_seq_reg)) begin
                            have_latest_next = 1'b1;
                            latest_seq_next  = item.rec_sequence;
                            latest_min_next  = item.soc_min[VAL_W-1:0];
                            latest_max_next  = item.soc_max[VAL_W-1:0];
                            latest_avg_next  = item.soc_avg[VAL_W-1:0];
                        end
                    end else begin
                        res.record_class = CLS_INVALID;
                    end
                    scan_index_next = scan_index_inc;
                    // sector full, next write wraps
                    if (scan_index_inc >= SLOT_W'(SLOTS)) begin
                        next_slot_next   = SLOT_W'(SLOTS);
                        scan_active_next = 1'b0;
                        ready_next       = 1'b1;
                    end
                end
            end
            OP_SAVE: begin
                pend_save_next  = 1'b0;
                pend_erase_next = 1'b0;
                if (!ready_reg) begin
                    res.status = ST_NOT_READY;
                end else if (!chk.in_range) begin
                    res.status = ST_RANGE;
                end else begin
                    pend_save_next     = 1'b1;
                    pend_erase_next    = wrap;
                    pend_min_next      = item.soc_min[VAL_W-1:0];
                    pend_max_next      = item.soc_max[VAL_W-1:0];
                    pend_avg_next      = item.soc_avg[VAL_W-1:0];
                    res.erase_first    = wrap;
                    res.write_slot     = wrap ? '0 : next_slot_reg;
                    res.write_sequence = next_seq_reg;
                    res.write_checksum = calc_sum(LOG_MAGIC, next_seq_reg, item.soc_min,
                                                  item.soc_max, item.soc_avg);
                end
            end
            OP_OUTCOME: begin
                if (!pend_save_reg) begin
                    res.status = ST_IGNORED;
                end else begin
                    res.erase_first    = pend_erase_reg;
                    res.write_slot     = plan_slot;
                    res.write_sequence = next_seq_reg;
                    res.write_checksum = calc_sum(LOG_MAGIC, next_seq_reg,
                                                  16'(pend_min_reg), 16'(pend_max_reg),
                                                  16'(pend_avg_reg));
                    if (pend_erase_reg && !item.erase_ok) begin
                        res.status = ST_FLASH_ERR;
                    end else begin
                        if (pend_erase_reg) begin
                            next_slot_next = '0;
                        end
                        if (item.write_ok) begin
                            // record committed
                            next_slot_next   = plan_slot + 1'b1;
                            next_seq_next    = next_seq_reg + 32'd1;
                            have_latest_next = 1'b1;
                            latest_seq_next  = next_seq_reg;
                            latest_min_next  = pend_min_reg;
                            latest_max_next  = pend_max_reg;
                            latest_avg_next  = pend_avg_reg;
                        end else begin
                            res.status = ST_FLASH_ERR;
                        end
                    end
                    pend_save_next  = 1'b0;
                    pend_erase_next = 1'b0;
                end
            end
            default: begin
                res.status = ST_IGNORED;
            end
        endcase

        res.ready_res  = ready_next;
        res.found      = have_latest_next;
        res.latest_min = latest_min_next;
        res.latest_max = latest_max_next;
        res.latest_avg = latest_avg_next;
    end

    // log state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg       <= 1'b0;
            scan_active_reg <= 1'b0;
            scan_index_reg  <= '0;
            next_slot_reg   <= '0;
            next_seq_reg    <= 32'd1;
            have_latest_reg <= 1'b0;
            latest_seq_reg  <= '0;
            latest_min_reg  <= '0;
            latest_max_reg  <= '0;
            latest_avg_reg  <= '0;
            pend_save_reg   <= 1'b0;
            pend_erase_reg  <= 1'b0;
            pend_min_reg    <= '0;
            pend_max_reg    <= '0;
            pend_avg_reg    <= '0;
        end else if (fire) begin
            ready_reg       <= ready_next;
            scan_active_reg <= scan_active_next;
            scan_index_reg  <= scan_index_next;
            next_slot_reg   <= next_slot_next;
            next_seq_reg    <= next_seq_next;
            have_latest_reg <= have_latest_next;
            latest_seq_reg  <= latest_seq_next;
            latest_min_reg  <= latest_min_next;
            latest_max_reg  <= latest_max_next;
            latest_avg_reg  <= latest_avg_next;
            pend_save_reg   <= pend_save_next;
            pend_erase_reg  <= pend_erase_next;
            pend_min_reg    <= pend_min_next;
            pend_max_reg    <= pend_max_next;
            pend_avg_reg    <= pend_avg_next;
        end
    end

    // a save can only be pending once the scan has finished
    a_pend_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_save_reg |-> ready_reg)
        else $error("pending save while not ready");

    // scanning and ready exclude each other
    a_scan_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(scan_active_reg && ready_reg))
        else $error("scan active while ready");

    // planned erase only belongs to a pending save
    a_erase_with_save: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_erase_reg |-> pend_save_reg)
        else $error("erase planned without pending save");

    // write pointer never runs past the end of the sector
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_slot_reg <= SLOT_W'(SLOTS))
        else $error("next slot beyond sector end");

endmodule
`default_nettype wire

FILE: design/flash_record_log_manager_core.sv
// Charge-state record log manager for one flash sector.
// Input stream (s_*): one request per beat, kind in s_tuser (start scan,
// scanned record, save request, save outcome), record words and flash
// flags in s_tdata. A scan is a start followed by the records of slot 0
// upward; it ends at the first blank slot, a failed read or the end of the sector.
// Result stream (m_*): exactly one result per request, status in m_tuser,
// the record class, readiness, planned write (slot, sequence, checksum,
// erase-first) and the newest record in m_tdata.
// A request accepted into the input register is processed from there into
// the result register, which drives m_tvalid and the result.
// One request per cycle is sustained while m_tready does not stall the
// result register; the log state is updated in the same edge that loads
// the output register, so a request may follow its predecessor in the
// next cycle.
// Reset (aresetn low, synchronous) empties both stages and returns the log
// state to not ready, no newest record, next sequence 1.
// When m_tready is low the result is held; the input register still takes
// one more request, after which s_tready drops until the result is taken.
`default_nettype none
module flash_record_log_manager_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // rec_magic, rec_sequence, soc_min, soc_max, soc_avg, rec_checksum,
    // read_ok, erase_ok, write_ok, zero pad
    input  wire [frlm_pkg::S_TDATA_W-1:0]     s_tdata,
    // op
    input  wire [1:0]                         s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // record_class, ready_res, write_slot, erase_first, write_sequence,
    // write_checksum, found, latest_min, latest_max, latest_avg, zero pad
    output logic [frlm_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [2:0]                        m_tuser
);
    import frlm_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    in_item_t in_item_next;
    logic     out_valid_reg;
    result_t  out_res_reg;
    result_t  res;
    rec_chk_t chk;
    logic     fire;

    // handshake between the two register stages
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // unpack the incoming request
    always_comb begin
        in_item_next.op           = op_t'(s_tuser);
        in_item_next.rec_magic    = s_tdata[31:0];
        in_item_next.rec_sequence = s_tdata[63:32];
        in_item_next.soc_min      = s_tdata[79:64];
        in_item_next.soc_max      = s_tdata[95:80];
        in_item_next.soc_avg      = s_tdata[111:96];
        in_item_next.rec_checksum = s_tdata[143:112];
        in_item_next.read_ok      = s_tdata[144];
        in_item_next.erase_ok     = s_tdata[145];
        in_item_next.write_ok     = s_tdata[146];
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item_next;
        end
    end

    frlm_rec_check u_rec_check (
        .item (in_item_reg),
        .chk  (chk)
    );

    frlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .chk     (chk),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    // pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {4'h0,
                       out_res_reg.latest_avg,
                       out_res_reg.latest_max,
                       out_res_reg.latest_min,
                       out_res_reg.found,
                       out_res_reg.write_checksum,
                       out_res_reg.write_sequence,
                       out_res_reg.erase_first,
                       out_res_reg.write_slot,
                       out_res_reg.ready_res,
                       out_res_reg.record_class};

    // input stage can only block while it holds a request
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    // a processed request always lands in the result register
    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed request lost");

    // a held result that is not taken stays valid
    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result dropped or changed");

endmodule
`default_nettype wire
